// ===== rtl/core/fclt_pkg.sv =====
// shared types and constants of the fat cluster link table
// no dependencies; imported by the controller, datapath and top level

package fclt_pkg;

	// request kinds carried on the slave-side tuser
	localparam logic [1:0] REQ_READ  = 2'd0;
	localparam logic [1:0] REQ_WRITE = 2'd1;
	localparam logic [1:0] REQ_LOAD  = 2'd2;
	localparam logic [1:0] REQ_NOP   = 2'd3;

	// entry packing modes
	localparam logic [1:0] MODE_12 = 2'd0;
	localparam logic [1:0] MODE_16 = 2'd1;
	localparam logic [1:0] MODE_32 = 2'd2;

	// configuration register indexes
	localparam logic [1:0] CFG_MODE   = 2'd0;
	localparam logic [1:0] CFG_COUNT  = 2'd1;
	localparam logic [1:0] CFG_COPYSZ = 2'd2;

	// end-of-chain thresholds
	localparam logic [11:0] EOC_12 = 12'hff0;
	localparam logic [15:0] EOC_16 = 16'hfff0;
	localparam logic [27:0] EOC_32 = 28'hffffff0;

	localparam int TABLE_COPIES = 2;

	// widest unreduced entry byte address: copy base plus four times the cluster
	localparam int ADDR_W = 19;

	localparam int IN_DATA_W  = 80;
	localparam int OUT_DATA_W = 32;

	typedef struct packed {
		logic       load_in;
		logic       red_init;
		logic       red_step;
		logic       rd_issue;
		logic       addr_reload;
		logic       wr_byte;
		logic       res_load;
		logic [1:0] byte_idx;
	} ctrl_cmd_t;

	typedef struct packed {
		logic [1:0] req;
		logic       oor;
		logic       last_byte;
	} dp_stat_t;

	// steps of the shift-and-subtract address wrap for a given memory size
	function automatic int red_steps(input int mem_bytes);
		int fl;
		fl = $clog2(mem_bytes + 1) - 1;
		if (fl >= ADDR_W - 1) return 1;
		return ADDR_W - fl;
	endfunction

endpackage

// ===== rtl/core/fclt_ram.sv =====
// generic single-port-write, single-port-read ram with registered read data
// no dependencies

module fclt_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ===== rtl/core/fclt_dp.sv =====
// datapath: config registers, request capture, address wrap, byte ram, merge and result
// depends on fclt_pkg and fclt_ram

module fclt_dp #(
	parameter int MEM_BYTES = 131072
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic [1:0]                          s_tuser,
	input  logic [fclt_pkg::IN_DATA_W-1:0]      s_tdata,
	input  logic                                cfg_wen,
	input  logic [1:0]                          cfg_idx,
	input  logic [16:0]                         cfg_data,
	input  fclt_pkg::ctrl_cmd_t                 cmd,
	output fclt_pkg::dp_stat_t                  st,
	output logic [fclt_pkg::OUT_DATA_W-1:0]     m_tdata
);

	import fclt_pkg::*;

	localparam int MEM_AW = $clog2(MEM_BYTES);
	localparam int MEM_W  = $clog2(MEM_BYTES + 1);
	localparam int RW     = (MEM_W > ADDR_W) ? MEM_W : ADDR_W;
	localparam int KMAX   = red_steps(MEM_BYTES) - 1;
	localparam logic [RW-1:0]     MOD_INIT = RW'(MEM_BYTES) << KMAX;
	localparam logic [MEM_AW:0]   MEM_END  = (MEM_AW + 1)'(MEM_BYTES);

	// configuration
	logic [1:0]  mode_q;
	logic [16:0] ccount_q;
	logic [16:0] cbytes_q;

	// captured request
	logic [1:0]  req_q;
	logic [15:0] cl_q;
	logic        copy_q;
	logic [31:0] nxt_q;
	logic [16:0] baddr_q;
	logic [7:0]  bval_q;

	// address wrap and byte walk
	logic [RW-1:0]     red_q;
	logic [RW-1:0]     mod_q;
	logic [RW-1:0]     red_next;
	logic [MEM_AW-1:0] cur_q;
	logic [MEM_AW-1:0] start_q;
	logic [MEM_AW:0]   cur_p1;
	logic [MEM_AW-1:0] cur_inc;
	logic [ADDR_W-1:0] base_a;
	logic [ADDR_W-1:0] off_a;
	logic [ADDR_W-1:0] entry_a;

	// read capture
	logic        rd_vld_s1;
	logic [1:0]  rd_idx_s1;
	logic [31:0] word_q;
	logic [7:0]  ram_rdata;
	logic [7:0]  ram_wdata;
	logic [31:0] new_word;

	// result
	logic        oor;
	logic [1:0]  last_idx;
	logic [11:0] v12;
	logic [27:0] v;
	logic        eoc_v;
	logic        rd_ok;
	logic [31:0] res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_16;
			ccount_q <= 17'd0;
			cbytes_q <= 17'd65536;
		end else if (cfg_wen) begin
			unique case (cfg_idx)
				CFG_MODE:   mode_q   <= cfg_data[1:0];
				CFG_COUNT:  ccount_q <= cfg_data;
				CFG_COPYSZ: cbytes_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			req_q   <= s_tuser;
			cl_q    <= s_tdata[15:0];
			copy_q  <= s_tdata[16];
			nxt_q   <= s_tdata[48:17];
			baddr_q <= s_tdata[65:49];
			bval_q  <= s_tdata[73:66];
		end
	end

	// unreduced byte address of the entry or of the raw load
	always_comb begin
		base_a = (TABLE_COPIES > 1 && copy_q) ? ADDR_W'(cbytes_q) : '0;
		case (mode_q)
			MODE_12: off_a = ADDR_W'(cl_q) + ADDR_W'(cl_q[15:1]);
			MODE_16: off_a = ADDR_W'({cl_q, 1'b0});
			default: off_a = ADDR_W'({cl_q, 2'b00});
		endcase
		entry_a = (req_q == REQ_LOAD) ? ADDR_W'(baddr_q) : base_a + off_a;
	end

	assign red_next = (red_q >= mod_q) ? red_q - mod_q : red_q;
	assign cur_p1   = {1'b0, cur_q} + (MEM_AW + 1)'(1);
	assign cur_inc  = (cur_p1 == MEM_END) ? '0 : cur_p1[MEM_AW-1:0];

	always_ff @(posedge clk) begin
		if (cmd.red_init) begin
			red_q <= RW'(entry_a);
			mod_q <= MOD_INIT;
		end else if (cmd.red_step) begin
			red_q <= red_next;
			mod_q <= mod_q >> 1;
		end
		if (cmd.red_step) begin
			cur_q   <= red_next[MEM_AW-1:0];
			start_q <= red_next[MEM_AW-1:0];
		end else if (cmd.addr_reload) begin
			cur_q <= start_q;
		end else if (cmd.rd_issue || cmd.wr_byte) begin
			cur_q <= cur_inc;
		end
	end

	// merged entry bytes; neighbor nibbles and reserved bits come from the read
	always_comb begin
		case (mode_q)
			MODE_12: begin
				if (cl_q[0]) new_word = {16'd0, nxt_q[11:0], word_q[3:0]};
				else         new_word = {16'd0, word_q[15:12], nxt_q[11:0]};
			end
			MODE_16: new_word = {16'd0, nxt_q[15:0]};
			default: new_word = {word_q[31:28], nxt_q[27:0]};
		endcase
		ram_wdata = (req_q == REQ_LOAD) ? bval_q : new_word[{cmd.byte_idx, 3'b000} +: 8];
	end

	fclt_ram #(
		.WIDTH (8),
		.DEPTH (MEM_BYTES)
	) u_ram (
		.clk   (clk),
		.we    (cmd.wr_byte),
		.waddr (cur_q),
		.wdata (ram_wdata),
		.raddr (cur_q),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_issue;
		end
	end

	always_ff @(posedge clk) begin
		rd_idx_s1 <= cmd.byte_idx;
		if (rd_vld_s1) begin
			word_q[{rd_idx_s1, 3'b000} +: 8] <= ram_rdata;
		end
	end

	// status
	assign oor = {1'b0, cl_q} >= ccount_q;

	always_comb begin
		if (req_q == REQ_LOAD) last_idx = 2'd0;
		else if (mode_q == MODE_12 || mode_q == MODE_16) last_idx = 2'd1;
		else last_idx = 2'd3;
	end

	assign st.req       = req_q;
	assign st.oor       = oor;
	assign st.last_byte = (cmd.byte_idx == last_idx);

	// decoded read value
	always_comb begin
		v12 = cl_q[0] ? word_q[15:4] : word_q[11:0];
		case (mode_q)
			MODE_12: begin
				v     = 28'(v12);
				eoc_v = v12 >= EOC_12;
			end
			MODE_16: begin
				v     = 28'(word_q[15:0]);
				eoc_v = word_q[15:0] >= EOC_16;
			end
			default: begin
				v     = word_q[27:0];
				eoc_v = word_q[27:0] >= EOC_32;
			end
		endcase
	end

	assign rd_ok = (req_q == REQ_READ) && !oor;

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_q <= {1'b0,
				(req_q == REQ_READ || req_q == REQ_WRITE) && oor,
				rd_ok && (v == 28'd0),
				rd_ok && eoc_v,
				rd_ok ? v : 28'd0};
		end
	end

	assign m_tdata = res_q;

endmodule

// ===== rtl/core/fclt_ctrl.sv =====
// controller: sequences capture, address wrap, byte reads, byte writes and result hand-off
// depends on fclt_pkg

module fclt_ctrl #(
	parameter int MEM_BYTES = 131072
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	output logic                m_tvalid,
	input  logic                m_tready,
	input  fclt_pkg::dp_stat_t  st,
	output fclt_pkg::ctrl_cmd_t cmd
);

	import fclt_pkg::*;

	localparam int RED_STEPS = red_steps(MEM_BYTES);
	localparam int CNT_W     = ($clog2(RED_STEPS) > 2) ? $clog2(RED_STEPS) : 2;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHK,
		S_RED,
		S_RD,
		S_TAIL,
		S_WR,
		S_DONE
	} state_t;

	state_t           state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	always_comb begin
		state_d      = state_q;
		cnt_d        = cnt_q;
		cmd          = '0;
		cmd.byte_idx = cnt_q[1:0];
		s_tready     = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.load_in = 1'b1;
					state_d     = S_CHK;
				end
			end
			S_CHK: begin
				if (st.req == REQ_NOP || (st.req != REQ_LOAD && st.oor)) begin
					state_d = S_DONE;
				end else begin
					cmd.red_init = 1'b1;
					cnt_d        = '0;
					state_d      = S_RED;
				end
			end
			S_RED: begin
				cmd.red_step = 1'b1;
				if (cnt_q == CNT_W'(RED_STEPS - 1)) begin
					cnt_d   = '0;
					state_d = (st.req == REQ_LOAD) ? S_WR : S_RD;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_RD: begin
				cmd.rd_issue = 1'b1;
				if (st.last_byte) begin
					cnt_d   = '0;
					state_d = S_TAIL;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_TAIL: begin
				if (st.req == REQ_READ) begin
					state_d = S_DONE;
				end else begin
					cmd.addr_reload = 1'b1;
					state_d         = S_WR;
				end
			end
			S_WR: begin
				cmd.wr_byte = 1'b1;
				if (st.last_byte) begin
					cnt_d   = '0;
					state_d = S_DONE;
				end else begin
					cnt_d = cnt_q + 1'b1;
				end
			end
			S_DONE: begin
				if (!m_tvalid || m_tready) begin
					cmd.res_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= S_IDLE;
			cnt_q    <= '0;
			m_tvalid <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			if (cmd.res_load) begin
				m_tvalid <= 1'b1;
			end else if (m_tready) begin
				m_tvalid <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/fat_cluster_link_table_core.sv =====
// one transaction at a time: capture, range check, W address wrap steps (2 at 128 KiB), then
// N byte reads for a link read, N byte reads and N byte writes for a link write or one byte
// write for a raw load; N = entry bytes (2 for 12/16-bit, 4 for 32-bit); the result sits in an
// output register, so the next transaction is taken while it waits
// arst_n clears control and config (16-bit mode, no clusters, 64 KiB copy); ram not cleared
// depends on fclt_pkg, fclt_ctrl, fclt_dp, fclt_ram

module fat_cluster_link_table_core #(
	parameter int MEM_BYTES = 131072       // table memory size in bytes
) (
	input  logic                            clk,
	input  logic                            arst_n,

	// request stream
	input  logic                            s_tvalid,
	output logic                            s_tready,
	input  logic [1:0]                      s_tuser,  // req_type
	// cluster[15:0], fat_copy[16], link_in[48:17], byte_address[65:49],
	// byte_value[73:66], zero[79:74]
	input  logic [fclt_pkg::IN_DATA_W-1:0]  s_tdata,

	// result stream
	output logic                            m_tvalid,
	input  logic                            m_tready,
	// link_value[27:0], end_of_chain[28], is_free[29], out_of_range[30], zero[31]
	output logic [fclt_pkg::OUT_DATA_W-1:0] m_tdata,

	// config writes: 0 entry_width_mode, 1 cluster_count, 2 copy_bytes
	input  logic                            cfg_wen,
	input  logic [1:0]                      cfg_idx,
	input  logic [16:0]                     cfg_data
);

	import fclt_pkg::*;

	ctrl_cmd_t cmd;   // controller to datapath
	dp_stat_t  st;    // datapath to controller

	// controller: walks capture, address wrap, byte reads then byte writes
	fclt_ctrl #(
		.MEM_BYTES (MEM_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.st       (st),
		.cmd      (cmd)
	);

	// datapath: holds the table ram, merges entry nibbles and builds the result
	fclt_dp #(
		.MEM_BYTES (MEM_BYTES)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data),
		.cmd      (cmd),
		.st       (st),
		.m_tdata  (m_tdata)
	);

endmodule

// ===== rtl/core/fclt_checker.sv =====
// port-level checks for the fat cluster link table, bound to the top level
// depends on fat_cluster_link_table_core

module fclt_port_checks (
	input logic        clk,
	input logic        arst_n,
	input logic        s_tvalid,
	input logic        s_tready,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [31:0] m_tdata
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// one transaction in flight: no accept right after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("request taken while busy");

	// out of range clears the read fields
	a_oor_clears: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[30] |-> m_tdata[29:0] == 30'd0)
		else $error("out of range result carries data");

	// free and end of chain exclude each other, pad bit stays zero
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> !(m_tdata[28] && m_tdata[29]) && !m_tdata[31])
		else $error("inconsistent result flags");

endmodule

bind fat_cluster_link_table_core fclt_port_checks u_fclt_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

// ===== tb/sv/fclt_checker.sv =====
// result checker for the fat cluster link table core: watches the request, result and config ports
// keeps its own copy of the table bytes and settings and compares every result transaction in order
// depends on fclt_pkg

module fclt_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_tvalid,
	input  logic                            s_tready,
	input  logic [1:0]                      s_tuser,  // req_type
	// cluster[15:0], fat_copy[16], link_in[48:17], byte_address[65:49],
	// byte_value[73:66], zero[79:74]
	input  logic [fclt_pkg::IN_DATA_W-1:0]  s_tdata,
	input  logic                            m_tvalid,
	input  logic                            m_tready,
	// link_value[27:0], end_of_chain[28], is_free[29], out_of_range[30], zero[31]
	input  logic [fclt_pkg::OUT_DATA_W-1:0] m_tdata,
	input  logic                            cfg_wen,
	input  logic [1:0]                      cfg_idx,
	input  logic [16:0]                     cfg_data,
	output int                              mismatch_count,
	output int                              results_waiting,
	output int                              results_checked
);
	timeunit 1ns;
	timeprecision 1ps;
	import fclt_pkg::*;

	localparam int unsigned TABLE_MEM_BYTES = 131072;

	typedef struct packed {
		logic [27:0] link_value;
		logic        end_of_chain;
		logic        is_free;
		logic        out_of_range;
	} link_result_t;

	bit [7:0]     table_mem [TABLE_MEM_BYTES];
	logic [1:0]   width_mode;
	logic [16:0]  cluster_limit;
	logic [16:0]  copy_size;
	link_result_t link_results_due [$];
	int           err_n;
	int           chk_n;

	// every table byte address wraps around the memory
	function automatic logic [7:0] mem_rd(input int unsigned addr);
		return table_mem[addr % TABLE_MEM_BYTES];
	endfunction

	task automatic mem_wr(input int unsigned addr, input logic [7:0] value);
		table_mem[addr % TABLE_MEM_BYTES] = value;
	endtask

	task automatic apply_request(input logic [1:0] req, input logic [15:0] cl,
			input logic copy_sel, input logic [31:0] link_in, input logic [16:0] byte_addr,
			input logic [7:0] byte_val, output link_result_t res);
		int unsigned base;
		int unsigned addr;
		logic [31:0] word;
		logic [7:0]  lo_byte;
		logic [7:0]  hi_byte;
		res = '0;
		if (TABLE_COPIES < 2)
			copy_sel = 1'b0;
		base = copy_sel ? copy_size : 17'd0;
		case (width_mode)
			MODE_12: addr = base + ((int'(cl) * 3) >> 1);
			MODE_16: addr = base + int'(cl) * 2;
			default: addr = base + int'(cl) * 4;
		endcase
		if (req == REQ_LOAD) begin
			mem_wr(byte_addr, byte_val);
		end else if (req == REQ_READ || req == REQ_WRITE) begin
			if ({1'b0, cl} >= cluster_limit) begin
				res.out_of_range = 1'b1;
			end else if (req == REQ_READ) begin
				word = {mem_rd(addr + 3), mem_rd(addr + 2), mem_rd(addr + 1), mem_rd(addr)};
				case (width_mode)
					MODE_12: begin
						// odd clusters sit in the upper 12 bits of the byte pair
						res.link_value   = cl[0] ? word[15:4] : word[11:0];
						res.end_of_chain = res.link_value[11:0] >= EOC_12;
					end
					MODE_16: begin
						res.link_value   = word[15:0];
						res.end_of_chain = word[15:0] >= EOC_16;
					end
					default: begin
						res.link_value   = word[27:0];
						res.end_of_chain = word[27:0] >= EOC_32;
					end
				endcase
				res.is_free = res.link_value == '0;
			end else begin
				case (width_mode)
					MODE_12: begin
						lo_byte = mem_rd(addr);
						hi_byte = mem_rd(addr + 1);
						if (cl[0]) begin
							mem_wr(addr, {link_in[3:0], lo_byte[3:0]});
							mem_wr(addr + 1, link_in[11:4]);
						end else begin
							mem_wr(addr, link_in[7:0]);
							mem_wr(addr + 1, {hi_byte[7:4], link_in[11:8]});
						end
					end
					MODE_16: begin
						mem_wr(addr, link_in[7:0]);
						mem_wr(addr + 1, link_in[15:8]);
					end
					default: begin
						// reserved top nibble of a 32-bit entry survives the write
						hi_byte = mem_rd(addr + 3);
						mem_wr(addr, link_in[7:0]);
						mem_wr(addr + 1, link_in[15:8]);
						mem_wr(addr + 2, link_in[23:16]);
						mem_wr(addr + 3, {hi_byte[7:4], link_in[27:24]});
					end
				endcase
			end
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch_ports
		link_result_t due;
		link_result_t got;
		link_result_t fresh;
		if (!arst_n) begin
			width_mode    = MODE_16;
			cluster_limit = '0;
			copy_size     = 17'h10000;
			link_results_due.delete();
			err_n = 0;
			chk_n = 0;
		end else begin
			// result side first: a result leaving now belongs to an older request
			if (m_tvalid && m_tready) begin
				got.link_value   = m_tdata[27:0];
				got.end_of_chain = m_tdata[28];
				got.is_free      = m_tdata[29];
				got.out_of_range = m_tdata[30];
				if (link_results_due.size() == 0) begin
					err_n++;
					$display("%0t: unexpected result transaction: link=%h eoc=%b free=%b oor=%b",
						$time, got.link_value, got.end_of_chain, got.is_free,
						got.out_of_range);
				end else begin
					due = link_results_due.pop_front();
					chk_n++;
					if (got.link_value !== due.link_value ||
							got.end_of_chain !== due.end_of_chain ||
							got.is_free !== due.is_free ||
							got.out_of_range !== due.out_of_range) begin
						err_n++;
						$display("%0t: expected link %h eoc %b free %b oor %b, got %h %b %b %b",
							$time,
							due.link_value, due.end_of_chain, due.is_free, due.out_of_range,
							got.link_value, got.end_of_chain, got.is_free, got.out_of_range);
					end
				end
			end
			if (cfg_wen) begin
				case (cfg_idx)
					CFG_MODE:   width_mode    = cfg_data[1:0];
					CFG_COUNT:  cluster_limit = cfg_data;
					CFG_COPYSZ: copy_size     = cfg_data;
					default:    ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				apply_request(s_tuser, s_tdata[15:0], s_tdata[16], s_tdata[48:17],
					s_tdata[65:49], s_tdata[73:66], fresh);
				link_results_due.insert(link_results_due.size(), fresh);
			end
		end
		mismatch_count  <= err_n;
		results_waiting <= link_results_due.size();
		results_checked <= chk_n;
	end

endmodule

// ===== tb/sv/fat_cluster_link_table_core_tb.sv =====
// testbench top for the fat cluster link table core: clock, reset, request and config stimulus
// and the verdict; prediction and comparison live in fclt_checker
// depends on fclt_pkg, fclt_checker and the core rtl

module fat_cluster_link_table_core_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import fclt_pkg::*;

	localparam int unsigned TABLE_MEM_BYTES = 131072;
	localparam logic [1:0]  MODE_RSVD       = 2'd3;  // unnamed packing code, decodes as 32-bit
	localparam int          LONG_HOLD       = 500;   // receiver hold-off that backs the core up
	localparam int          WATCHDOG_LIMIT  = 4000;  // idle cycles before the run is declared hung
	localparam int          TAIL_CYCLES     = 32;    // well over the longest link write occupancy

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [1:0]            s_tuser;   // req_type
	// cluster[15:0], fat_copy[16], link_in[48:17], byte_address[65:49],
	// byte_value[73:66], zero[79:74]
	logic [IN_DATA_W-1:0]  s_tdata;
	logic                  m_tvalid;
	logic                  m_tready;
	// link_value[27:0], end_of_chain[28], is_free[29], out_of_range[30], zero[31]
	logic [OUT_DATA_W-1:0] m_tdata;
	logic                  cfg_wen;
	logic [1:0]            cfg_idx;
	logic [16:0]           cfg_data;

	int mismatch_count;
	int results_waiting;
	int results_checked;

	// settings as last written, needed to know which table bytes an access touches
	logic [1:0]  mode_now;
	int          count_now;
	int unsigned copysz_now;
	int          win_lo;

	// table bytes that hold loaded data; link accesses never touch anything else
	bit loaded [TABLE_MEM_BYTES];

	int items_sent;
	int req_seen [4];
	int settings_used;
	bit steady;          // no idling on either side while set
	bit long_hold_req;   // asks the receiver for one long hold-off

	fat_cluster_link_table_core #(
		.MEM_BYTES(TABLE_MEM_BYTES)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tuser  (s_tuser),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.cfg_wen  (cfg_wen),
		.cfg_idx  (cfg_idx),
		.cfg_data (cfg_data)
	);

	fclt_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.s_tvalid        (s_tvalid),
		.s_tready        (s_tready),
		.s_tuser         (s_tuser),
		.s_tdata         (s_tdata),
		.m_tvalid        (m_tvalid),
		.m_tready        (m_tready),
		.m_tdata         (m_tdata),
		.cfg_wen         (cfg_wen),
		.cfg_idx         (cfg_idx),
		.cfg_data        (cfg_data),
		.mismatch_count  (mismatch_count),
		.results_waiting (results_waiting),
		.results_checked (results_checked)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// mostly back-to-back or short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// one request transaction; returns at the edge that accepted it with tvalid still high,
	// so a following call without a gap keeps the stream going
	task automatic send(input logic [1:0] req, input logic [15:0] cl, input logic copy_sel,
			input logic [31:0] link_in, input logic [16:0] byte_addr, input logic [7:0] byte_val);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= req;
		s_tdata  <= {6'd0, byte_val, byte_addr, link_in, copy_sel, cl};
		do @(posedge clk); while (!s_tready);
		items_sent++;
		req_seen[req]++;
	endtask

	// link read or write; an in-range access first gets its entry bytes loaded if they never were,
	// which makes the usual load-then-link sequence with random byte contents
	task automatic link_op(input logic [1:0] req, input logic [15:0] cl, input logic copy_sel,
			input logic [31:0] link_in);
		int unsigned addr;
		int unsigned slot;
		int          nbytes;
		if (int'(cl) < count_now) begin
			addr = copy_sel ? copysz_now : 0;
			case (mode_now)
				MODE_12: addr += (int'(cl) * 3) >> 1;
				MODE_16: addr += int'(cl) * 2;
				default: addr += int'(cl) * 4;
			endcase
			nbytes = (mode_now == MODE_12 || mode_now == MODE_16) ? 2 : 4;
			for (int i = 0; i < nbytes; i++) begin
				slot = (addr + i) % TABLE_MEM_BYTES;
				if (!loaded[slot]) begin
					send(REQ_LOAD, 16'($urandom), 1'($urandom), $urandom, 17'(slot),
						8'($urandom));
					loaded[slot] = 1'b1;
				end
			end
		end
		send(req, cl, copy_sel, link_in, 17'($urandom), 8'($urandom));
	endtask

	// mostly a 32-entry window so reads see earlier writes and neighbor nibbles interact
	function automatic logic [15:0] pick_cluster();
		int last_cl;
		int lo;
		if (count_now == 0 || $urandom_range(0, 9) < 3)
			return 16'($urandom);
		last_cl = count_now - 1;
		lo = (win_lo > last_cl) ? 0 : win_lo;
		return 16'($urandom_range(lo, (lo + 31 > last_cl) ? last_cl : lo + 31));
	endfunction

	// new entry values: free, around the end-of-chain threshold, or anything;
	// bits above the entry width stay random to show they are dropped
	function automatic logic [31:0] pick_link();
		logic [31:0] v;
		logic [31:0] mask;
		logic [31:0] thr;
		v = $urandom;
		case (mode_now)
			MODE_12: begin
				mask = 32'h0000_0fff;
				thr  = 32'(EOC_12);
			end
			MODE_16: begin
				mask = 32'h0000_ffff;
				thr  = 32'(EOC_16);
			end
			default: begin
				mask = 32'h0fff_ffff;
				thr  = 32'(EOC_32);
			end
		endcase
		case ($urandom_range(0, 3))
			0:       v = v & ~mask;
			1:       v = (v & ~mask) | ((thr - 4 + $urandom_range(0, 19)) & mask);
			default: ;
		endcase
		return v;
	endfunction

	// drop the request stream and wait for every result to drain
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (results_waiting != 0);
		repeat (4) @(posedge clk);
	endtask

	// write all three registers while the core is idle
	task automatic configure(input logic [1:0] mode, input int count, input int copysz);
		settle();
		cfg_wen  <= 1'b1;
		cfg_idx  <= CFG_MODE;
		cfg_data <= 17'(mode);
		@(posedge clk);
		cfg_idx  <= CFG_COUNT;
		cfg_data <= 17'(count);
		@(posedge clk);
		cfg_idx  <= CFG_COPYSZ;
		cfg_data <= 17'(copysz);
		@(posedge clk);
		cfg_wen    <= 1'b0;
		mode_now   = mode;
		count_now  = count;
		copysz_now = copysz;
		// sometimes park the window at the top of the valid range
		win_lo = (count > 32 && $urandom_range(0, 2) == 0) ? count - 32 : $urandom_range(0, 65535);
		settings_used++;
	endtask

	// random traffic: mostly link reads and writes, some out-of-range, byte noise and no-ops
	task automatic run_phase(input int n);
		int          stop;
		int          r;
		logic [15:0] cl;
		logic [16:0] addr;
		stop = items_sent + n;
		while (items_sent < stop) begin
			r  = $urandom_range(0, 99);
			cl = pick_cluster();
			if (r < 6) begin
				addr = 17'($urandom);
				send(REQ_LOAD, cl, 1'($urandom), $urandom, addr, 8'($urandom));
				loaded[addr] = 1'b1;
			end else if (r < 10) begin
				send(REQ_NOP, cl, 1'($urandom), $urandom, 17'($urandom), 8'($urandom));
			end else if (r < 16 && count_now < 65536) begin
				link_op(r[0] ? REQ_READ : REQ_WRITE, 16'($urandom_range(count_now, 65535)),
					1'($urandom), $urandom);
			end else if (r < 58) begin
				link_op(REQ_READ, cl, 1'($urandom), $urandom);
			end else begin
				link_op(REQ_WRITE, cl, 1'($urandom), pick_link());
			end
		end
	endtask

	// result side: random tready, one long hold-off on request, none while steady
	initial begin
		int hold;
		m_tready = 1'b0;
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				long_hold_req = 1'b0;
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (steady) begin
				m_tready <= 1'b1;
				@(posedge clk);
			end else begin
				m_tready <= 1'b1;
				repeat ($urandom_range(1, 12)) @(posedge clk);
				hold = pick_gap();
				if (hold > 0) begin
					m_tready <= 1'b0;
					repeat (hold) @(posedge clk);
				end
			end
		end
	end

	// watchdog: ends the run when neither channel moves a transaction for too long
	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !arst_n)
				quiet = 0;
			else
				quiet++;
		end
		$display("%0t: timeout, no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
		$display("DONE: errors detected");
		$finish;
	end

	initial begin
		arst_n        = 1'b0;
		s_tvalid      = 1'b0;
		s_tuser       = REQ_NOP;
		s_tdata       = '0;
		cfg_wen       = 1'b0;
		cfg_idx       = CFG_MODE;
		cfg_data      = '0;
		mode_now      = MODE_16;
		count_now     = 0;
		copysz_now    = 65536;
		win_lo        = 0;
		items_sent    = 0;
		settings_used = 1;
		steady        = 1'b0;
		long_hold_req = 1'b0;
		foreach (req_seen[i])
			req_seen[i] = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings leave no valid cluster: link accesses report out of range
		send(REQ_NOP, 16'hffff, 1'b1, 32'hffff_ffff, 17'h1ffff, 8'hff);
		link_op(REQ_READ, 16'h0000, 1'b0, 32'h0000_0000);
		link_op(REQ_WRITE, 16'hffff, 1'b1, 32'hffff_ffff);
		// byte loads at both ends of the memory
		send(REQ_LOAD, 16'h0000, 1'b0, 32'h0000_0000, 17'h1ffff, 8'h5a);
		loaded[17'h1ffff] = 1'b1;
		send(REQ_LOAD, 16'hffff, 1'b1, 32'hffff_ffff, 17'h00000, 8'ha5);
		loaded[17'h00000] = 1'b1;

		// 12-bit pair sharing a byte: each write must keep the other entry's nibble
		configure(MODE_12, 65536, 65536);
		link_op(REQ_WRITE, 16'd0, 1'b0, 32'hffff_fff0);
		link_op(REQ_WRITE, 16'd1, 1'b0, 32'h0000_0fff);
		link_op(REQ_READ, 16'd0, 1'b0, 32'h0);
		link_op(REQ_READ, 16'd1, 1'b0, 32'h0);
		link_op(REQ_WRITE, 16'd1, 1'b0, 32'h0000_0000);
		link_op(REQ_READ, 16'd1, 1'b0, 32'h0);
		link_op(REQ_READ, 16'd0, 1'b0, 32'h0);
		// top cluster in the second copy runs past the memory end and wraps
		link_op(REQ_WRITE, 16'hffff, 1'b1, 32'h1234_5fef);
		link_op(REQ_READ, 16'hffff, 1'b1, 32'h0);

		// 32-bit entries: reserved nibble kept, threshold hit exactly
		configure(MODE_32, 65536, 65536);
		link_op(REQ_WRITE, 16'hffff, 1'b1, 32'hffff_ffff);
		link_op(REQ_READ, 16'hffff, 1'b1, 32'h0);
		link_op(REQ_WRITE, 16'hffff, 1'b1, 32'h0fff_fff0);
		link_op(REQ_READ, 16'hffff, 1'b1, 32'h0);

		// random phases over a spread of settings, extremes included
		configure(MODE_12, 4085, 6144);
		run_phase(170);
		configure(MODE_16, 65536, 65536);
		long_hold_req = 1'b1;  // receiver stalls while requests keep coming
		run_phase(170);
		configure(MODE_32, 65536, 0);  // both copies alias onto one table
		steady = 1'b1;
		run_phase(170);
		steady = 1'b0;
		configure(MODE_RSVD, 1000, 65535);
		run_phase(170);
		configure(MODE_12, 65535, 1);
		run_phase(170);
		configure(MODE_16, 1, 0);
		run_phase(100);
		configure(MODE_12, 65536, 0);
		run_phase(170);
		configure(MODE_32, 0, 65536);
		run_phase(50);

		settle();
		repeat (TAIL_CYCLES) @(posedge clk);
		$display("covered %0d requests: %0d link reads, %0d link writes, %0d byte loads, %0d no-ops",
			items_sent, req_seen[REQ_READ], req_seen[REQ_WRITE], req_seen[REQ_LOAD],
			req_seen[REQ_NOP]);
		$display("across %0d table settings (12/16/32-bit and reserved packing), %0d results compared",
			settings_used, results_checked);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
